// ===== rtl/ray_triangle_intersect_assert.svh =====
// Assertion macros for the ray/triangle intersection RTL.
`ifndef RAY_TRIANGLE_INTERSECT_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define RTI_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define RTI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rti_pkg.sv =====
// Types and constants shared by the ray/triangle intersection modules.
`default_nettype none

package rti_pkg;

  // Field widths of the item formats.
  localparam int COORD_W    = 32;
  localparam int IDX_W      = 10;
  localparam int CORNER_W   = 2;
  localparam int EPS_W      = 16;
  localparam int NUM_CORNERS = 3;

  // One stored triangle: three corners of x, y, z, x in the low bits.
  localparam int VTX_W = 3 * COORD_W;
  localparam int TRI_W = NUM_CORNERS * VTX_W;

  // Exact datapath widths.
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int SPLIT_W = 34;
  localparam int LO_W    = SPLIT_W + 1 + DIFF_W;
  localparam int HI_W    = (CROSS_W - SPLIT_W) + DIFF_W;
  localparam int WIDE_W  = 104;
  localparam int QUO_W   = 31;
  localparam int DIV_W   = WIDE_W + QUO_W;
  localparam int BARY_FRAC = 30;

  // Item codes.
  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_TEST  = 1'b1;

  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);
  localparam logic [QUO_W-1:0] DIST_MAX  = '1;
  localparam logic [QUO_W-1:0] BARY_ONE  = QUO_W'(1) << BARY_FRAC;

  typedef struct packed {
    logic                      func;
    logic [IDX_W-1:0]          tri_index;
    logic [CORNER_W-1:0]       corner;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
  } rti_req_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] tri_echo;
    logic [QUO_W-1:0] bary_u;
    logic [QUO_W-1:0] bary_v;
    logic [QUO_W-1:0] hit_distance;
  } rti_rsp_t;

  // Status that travels beside the dividers.
  typedef struct packed {
    logic             hit;
    logic             sat;
    logic [IDX_W-1:0] tri_index;
  } rti_side_t;

endpackage

`default_nettype wire

// ===== rtl/ray_triangle_intersect.sv =====
// Top level of the Moller-Trumbore ray/triangle intersection unit.
// Usage:
//   The req channel (valid/ready) carries store and test items. A store item
//   writes one corner of one triangle slot and gives no result. A test item
//   gives exactly one item on the rsp channel, in order of acceptance.
//   cfg_we/cfg_wdata write the determinant threshold; write it only while idle.
// Rate and pipeline:
//   One item is accepted every cycle while req_ready is high. A test result
//   then passes through seven arithmetic stages (the first works on the data
//   of the triangle store read), one decision stage, 31 divider stages (one
//   quotient bit each) and the write into the two-entry response buffer.
//   The triangle store is one RAM word per triangle; a store item reads the
//   word, merges its corner and writes it back, with a forwarding register
//   covering back-to-back items on the same slot.
// Reset and stalls:
//   Reset empties the pipeline and the response buffer and sets the threshold
//   to one. The triangle store is not cleared; test only written slots.
//   When rsp_ready is low the buffer still takes two results; after that
//   the pipeline and req_ready hold only while a finished result is waiting.
`default_nettype none

module ray_triangle_intersect import rti_pkg::*; #(
  parameter int MAX_TRIANGLES   = 1024,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [EPS_W-1:0] cfg_wdata,
  input  logic             req_valid,
  output logic             req_ready,
  input  rti_req_t         req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rti_rsp_t         rsp
);

  `include "ray_triangle_intersect_assert.svh"

  localparam int AW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;

  logic adv;

  // Threshold register.
  logic [EPS_W-1:0] det_epsilon;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_epsilon <= EPS_RESET;
    end else if (cfg_we) begin
      det_epsilon <= cfg_wdata;
    end
  end

  // Stage 1: item waits for the store read.
  logic          s1_valid;
  rti_req_t      s1_req;
  logic          s1_inrange;
  logic [AW-1:0] s1_addr;
  logic [AW-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_req     <= req;
      s1_inrange <= 32'(req.tri_index) < MAX_TRIANGLES;
    end
  end

  assign rd_addr = AW'(req.tri_index);
  assign s1_addr = AW'(s1_req.tri_index);

  // Triangle store and its forwarding register.
  logic             ram_we;
  logic [TRI_W-1:0] ram_wdata;
  logic [TRI_W-1:0] ram_rdata;
  logic [TRI_W-1:0] cur_word;
  logic             fwd_valid;
  logic [AW-1:0]    fwd_addr;
  logic [TRI_W-1:0] fwd_data;

  rti_ram #(
    .WIDTH(TRI_W),
    .DEPTH(MAX_TRIANGLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (ram_wdata),
    .re    (adv),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign ram_we = adv && s1_valid && (s1_req.func == FUNC_STORE) && s1_inrange &&
                  (s1_req.corner < CORNER_W'(NUM_CORNERS));

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (ram_we) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_addr <= s1_addr;
      fwd_data <= ram_wdata;
    end
  end

  // Merge the new corner into the current word; form the edges.
  logic signed [COORD_W-1:0] org_c [3];
  logic signed [DIFF_W-1:0]  e1_c [3];
  logic signed [DIFF_W-1:0]  e2_c [3];
  logic signed [DIFF_W-1:0]  s_c  [3];

  always_comb begin
    cur_word = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_data : ram_rdata;
    ram_wdata = cur_word;
    for (int c = 0; c < NUM_CORNERS; c++) begin
      if (s1_req.corner == CORNER_W'(c)) begin
        ram_wdata[c*VTX_W +: VTX_W] = {s1_req.pos_z, s1_req.pos_y, s1_req.pos_x};
      end
    end
    org_c[0] = s1_req.pos_x;
    org_c[1] = s1_req.pos_y;
    org_c[2] = s1_req.pos_z;
    for (int i = 0; i < 3; i++) begin
      e1_c[i] = $signed(cur_word[VTX_W + i*COORD_W +: COORD_W]) -
                $signed(cur_word[i*COORD_W +: COORD_W]);
      e2_c[i] = $signed(cur_word[2*VTX_W + i*COORD_W +: COORD_W]) -
                $signed(cur_word[i*COORD_W +: COORD_W]);
      s_c[i]  = org_c[i] - $signed(cur_word[i*COORD_W +: COORD_W]);
    end
  end

  // Stage 2: only test items continue.
  logic                      s2_valid;
  logic [IDX_W-1:0]          s2_tri;
  logic                      s2_inrange;
  logic signed [COORD_W-1:0] s2_dir [3];
  logic signed [DIFF_W-1:0]  s2_e1 [3];
  logic signed [DIFF_W-1:0]  s2_e2 [3];
  logic signed [DIFF_W-1:0]  s2_s  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && (s1_req.func == FUNC_TEST);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_tri     <= s1_req.tri_index;
      s2_inrange <= s1_inrange;
      s2_dir[0]  <= s1_req.dir_x;
      s2_dir[1]  <= s1_req.dir_y;
      s2_dir[2]  <= s1_req.dir_z;
      s2_e1      <= e1_c;
      s2_e2      <= e2_c;
      s2_s       <= s_c;
    end
  end

  // Cross product terms of dir x e2 and s x e1.
  logic signed [PROD_W-1:0] pa_c [3];
  logic signed [PROD_W-1:0] pb_c [3];
  logic signed [PROD_W-1:0] qa_c [3];
  logic signed [PROD_W-1:0] qb_c [3];

  always_comb begin
    pa_c[0] = s2_dir[1] * s2_e2[2];
    pb_c[0] = s2_dir[2] * s2_e2[1];
    pa_c[1] = s2_dir[2] * s2_e2[0];
    pb_c[1] = s2_dir[0] * s2_e2[2];
    pa_c[2] = s2_dir[0] * s2_e2[1];
    pb_c[2] = s2_dir[1] * s2_e2[0];
    qa_c[0] = s2_s[1] * s2_e1[2];
    qb_c[0] = s2_s[2] * s2_e1[1];
    qa_c[1] = s2_s[2] * s2_e1[0];
    qb_c[1] = s2_s[0] * s2_e1[2];
    qa_c[2] = s2_s[0] * s2_e1[1];
    qb_c[2] = s2_s[1] * s2_e1[0];
  end

  // Stage 3.
  logic                      s3_valid;
  logic [IDX_W-1:0]          s3_tri;
  logic                      s3_inrange;
  logic signed [COORD_W-1:0] s3_dir [3];
  logic signed [DIFF_W-1:0]  s3_e1 [3];
  logic signed [DIFF_W-1:0]  s3_e2 [3];
  logic signed [DIFF_W-1:0]  s3_s  [3];
  logic signed [PROD_W-1:0]  s3_pa [3];
  logic signed [PROD_W-1:0]  s3_pb [3];
  logic signed [PROD_W-1:0]  s3_qa [3];
  logic signed [PROD_W-1:0]  s3_qb [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_tri     <= s2_tri;
      s3_inrange <= s2_inrange;
      s3_dir     <= s2_dir;
      s3_e1      <= s2_e1;
      s3_e2      <= s2_e2;
      s3_s       <= s2_s;
      s3_pa      <= pa_c;
      s3_pb      <= pb_c;
      s3_qa      <= qa_c;
      s3_qb      <= qb_c;
    end
  end

  // The cross products themselves.
  logic signed [CROSS_W-1:0] p_c [3];
  logic signed [CROSS_W-1:0] q_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_c[i] = s3_pa[i] - s3_pb[i];
      q_c[i] = s3_qa[i] - s3_qb[i];
    end
  end

  // Stage 4.
  logic                      s4_valid;
  logic [IDX_W-1:0]          s4_tri;
  logic                      s4_inrange;
  logic signed [COORD_W-1:0] s4_dir [3];
  logic signed [DIFF_W-1:0]  s4_e1 [3];
  logic signed [DIFF_W-1:0]  s4_e2 [3];
  logic signed [DIFF_W-1:0]  s4_s  [3];
  logic signed [CROSS_W-1:0] s4_p [3];
  logic signed [CROSS_W-1:0] s4_q [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_tri     <= s3_tri;
      s4_inrange <= s3_inrange;
      s4_dir     <= s3_dir;
      s4_e1      <= s3_e1;
      s4_e2      <= s3_e2;
      s4_s       <= s3_s;
      s4_p       <= p_c;
      s4_q       <= q_c;
    end
  end

  // Split products: groups are det (p.e1), u (p.s), v (q.dir) and t (q.e2).
  // Each wide cross term is cut into a signed high half and an unsigned low half.
  logic signed [LO_W-1:0] mlo_c [4][3];
  logic signed [HI_W-1:0] mhi_c [4][3];

  always_comb begin
    logic signed [CROSS_W-1:0] a;
    logic signed [DIFF_W-1:0]  b;
    for (int g = 0; g < 4; g++) begin
      for (int i = 0; i < 3; i++) begin
        a = (g < 2) ? s4_p[i] : s4_q[i];
        case (g)
          0:       b = s4_e1[i];
          1:       b = s4_s[i];
          2:       b = DIFF_W'(s4_dir[i]);
          default: b = s4_e2[i];
        endcase
        mlo_c[g][i] = $signed({1'b0, a[SPLIT_W-1:0]}) * b;
        mhi_c[g][i] = $signed(a[CROSS_W-1:SPLIT_W]) * b;
      end
    end
  end

  // Stage 5.
  logic                   s5_valid;
  logic [IDX_W-1:0]       s5_tri;
  logic                   s5_inrange;
  logic signed [LO_W-1:0] s5_mlo [4][3];
  logic signed [HI_W-1:0] s5_mhi [4][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (adv) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_tri     <= s4_tri;
      s5_inrange <= s4_inrange;
      s5_mlo     <= mlo_c;
      s5_mhi     <= mhi_c;
    end
  end

  // Recombine the halves into exact products.
  logic signed [WIDE_W-1:0] prod_c [4][3];

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      for (int i = 0; i < 3; i++) begin
        prod_c[g][i] = (WIDE_W'(s5_mhi[g][i]) <<< SPLIT_W) + WIDE_W'(s5_mlo[g][i]);
      end
    end
  end

  // Stage 6.
  logic                     s6_valid;
  logic [IDX_W-1:0]         s6_tri;
  logic                     s6_inrange;
  logic signed [WIDE_W-1:0] s6_prod [4][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (adv) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_tri     <= s5_tri;
      s6_inrange <= s5_inrange;
      s6_prod    <= prod_c;
    end
  end

  // Dot products: determinant and the three numerators.
  logic signed [WIDE_W-1:0] sum_c [4];

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      sum_c[g] = s6_prod[g][0] + s6_prod[g][1] + s6_prod[g][2];
    end
  end

  // Stage 7.
  logic                     s7_valid;
  logic [IDX_W-1:0]         s7_tri;
  logic                     s7_inrange;
  logic signed [WIDE_W-1:0] s7_sum [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else if (adv) begin
      s7_valid <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_tri     <= s6_tri;
      s7_inrange <= s6_inrange;
      s7_sum     <= sum_c;
    end
  end

  // Fold the determinant sign into the numerators.
  logic              det_neg;
  logic [WIDE_W-1:0] mag_c;
  logic [WIDE_W-1:0] nu_c;
  logic [WIDE_W-1:0] nv_c;
  logic [WIDE_W-1:0] nt_c;
  logic              detz_c;

  always_comb begin
    det_neg = s7_sum[0][WIDE_W-1];
    mag_c   = det_neg ? -s7_sum[0] : s7_sum[0];
    nu_c    = det_neg ? -s7_sum[1] : s7_sum[1];
    nv_c    = det_neg ? -s7_sum[2] : s7_sum[2];
    nt_c    = det_neg ? -s7_sum[3] : s7_sum[3];
    detz_c  = s7_sum[0] == '0;
  end

  // Stage 8.
  logic              s8_valid;
  logic [IDX_W-1:0]  s8_tri;
  logic              s8_inrange;
  logic [WIDE_W-1:0] s8_mag;
  logic [WIDE_W-1:0] s8_nu;
  logic [WIDE_W-1:0] s8_nv;
  logic [WIDE_W-1:0] s8_nt;
  logic              s8_detz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else if (adv) begin
      s8_valid <= s7_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_tri     <= s7_tri;
      s8_inrange <= s7_inrange;
      s8_mag     <= mag_c;
      s8_nu      <= nu_c;
      s8_nv      <= nv_c;
      s8_nt      <= nt_c;
      s8_detz    <= detz_c;
    end
  end

  // Hit decision, distance saturation and divider operands.
  logic [WIDE_W-1:0] thr;
  logic [WIDE_W:0]   uv_sum;
  logic              hit_c;
  logic              sat_c;
  logic [DIV_W-1:0]  num_u_c;
  logic [DIV_W-1:0]  num_v_c;
  logic [DIV_W-1:0]  num_t_c;

  always_comb begin
    thr    = WIDE_W'(det_epsilon) << (2 * COORD_FRAC_BITS);
    uv_sum = (WIDE_W + 1)'(s8_nu) + (WIDE_W + 1)'(s8_nv);
    hit_c  = s8_inrange && !s8_detz && (s8_mag >= thr) &&
             !s8_nu[WIDE_W-1] && (s8_nu <= s8_mag) &&
             !s8_nv[WIDE_W-1] && (uv_sum <= {1'b0, s8_mag}) &&
             !s8_nt[WIDE_W-1];
    sat_c  = DIV_W'(s8_nt) >= (DIV_W'(s8_mag) << (QUO_W - COORD_FRAC_BITS));
    num_u_c = DIV_W'(s8_nu) << BARY_FRAC;
    num_v_c = DIV_W'(s8_nv) << BARY_FRAC;
    num_t_c = DIV_W'(s8_nt) << COORD_FRAC_BITS;
  end

  // Divider input registers.
  logic              dv_valid;
  rti_side_t         dv_side;
  logic [DIV_W-1:0]  dv_num_u;
  logic [DIV_W-1:0]  dv_num_v;
  logic [DIV_W-1:0]  dv_num_t;
  logic [WIDE_W-1:0] dv_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid <= 1'b0;
    end else if (adv) begin
      dv_valid <= s8_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_side.hit       <= hit_c;
      dv_side.sat       <= sat_c;
      dv_side.tri_index <= s8_tri;
      dv_num_u          <= num_u_c;
      dv_num_v          <= num_v_c;
      dv_num_t          <= num_t_c;
      dv_den            <= s8_mag;
    end
  end

  // Three dividers share the determinant magnitude as divisor.
  logic [QUO_W-1:0] quo_u;
  logic [QUO_W-1:0] quo_v;
  logic [QUO_W-1:0] quo_t;

  rti_div u_div_u (.clk(clk), .en(adv), .num(dv_num_u), .den(dv_den), .quo(quo_u));
  rti_div u_div_v (.clk(clk), .en(adv), .num(dv_num_v), .den(dv_den), .quo(quo_v));
  rti_div u_div_t (.clk(clk), .en(adv), .num(dv_num_t), .den(dv_den), .quo(quo_t));

  // Status line matching the divider depth.
  logic [QUO_W-1:0] side_valid;
  rti_side_t        side [QUO_W];
  rti_side_t        last;
  logic             last_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_valid <= '0;
    end else if (adv) begin
      side_valid <= {side_valid[QUO_W-2:0], dv_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= dv_side;
      for (int j = 1; j < QUO_W; j++) begin
        side[j] <= side[j-1];
      end
    end
  end

  assign last       = side[QUO_W-1];
  assign last_valid = side_valid[QUO_W-1];

  // Result item; a miss reports zero barycentrics and distance.
  rti_rsp_t fill;

  always_comb begin
    fill.hit          = last.hit;
    fill.tri_echo     = last.tri_index;
    fill.bary_u       = last.hit ? quo_u : '0;
    fill.bary_v       = last.hit ? quo_v : '0;
    fill.hit_distance = !last.hit ? '0 : (last.sat ? DIST_MAX : quo_t);
  end

  // Two-entry response buffer; the pipeline holds only when it is full and a finished result is waiting.
  rti_rsp_t   rbuf [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] rcnt;
  logic       push;
  logic       pop;
  logic       full;

  assign full      = rcnt == 2'd2;
  assign adv       = !(last_valid && full);
  assign req_ready = adv;
  assign push      = adv && last_valid;
  assign rsp_valid = rcnt != 2'd0;
  assign pop       = rsp_valid && rsp_ready;
  assign rsp       = rbuf[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      rcnt <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      rcnt <= rcnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rbuf[wptr] <= fill;
    end
  end

  // Checks on the result path.
  `RTI_ASSERT(a_buf_bound, 1'b1, rcnt <= 2'd2, "response buffer count out of range")
  `RTI_ASSERT(a_bary_sum, rsp_valid && rsp.hit,
              (32'(rsp.bary_u) + 32'(rsp.bary_v)) <= 32'(BARY_ONE),
              "barycentric sum above one")
  `RTI_ASSERT(a_miss_zero, rsp_valid && !rsp.hit,
              (rsp.bary_u == '0) && (rsp.bary_v == '0) && (rsp.hit_distance == '0),
              "miss item with non-zero fields")
  `RTI_ASSERT_NEXT(a_stall_hold, last_valid && !adv, last_valid && (rcnt != 2'd0),
                   "finished item lost while stalled")

endmodule

`default_nettype wire

// ===== rtl/rti_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; a read of the address being written returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rti_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module rti_div import rti_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [DIV_W-1:0]  num,
  input  logic [WIDE_W-1:0] den,
  output logic [QUO_W-1:0]  quo
);

  // The numerator must be below den * 2^QUO_W, so every quotient fits.
  logic [DIV_W-1:0]  rem  [QUO_W-1];
  logic [WIDE_W-1:0] dsr  [QUO_W-1];
  logic [QUO_W-1:0]  qacc [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    localparam int B = QUO_W - 1 - i;
    logic [DIV_W-1:0]  r_in;
    logic [WIDE_W-1:0] d_in;
    logic [QUO_W-1:0]  q_in;
    logic [DIV_W:0]    diff;

    if (i == 0) begin : g_first
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem[i-1];
      assign d_in = dsr[i-1];
      assign q_in = qacc[i-1];
    end

    // Trial subtraction of the divisor aligned to this quotient bit.
    assign diff = {1'b0, r_in} - ((DIV_W + 1)'(d_in) << B);

    always_ff @(posedge clk) begin
      if (en) begin
        qacc[i] <= diff[DIV_W] ? q_in : (q_in | (QUO_W'(1) << B));
      end
    end

    if (i < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i] <= diff[DIV_W] ? r_in : diff[DIV_W-1:0];
          dsr[i] <= d_in;
        end
      end
    end
  end

  assign quo = qacc[QUO_W-1];

endmodule

`default_nettype wire

// ===== test/ray_triangle_intersect_tb.sv =====
// Self-checking testbench for the ray/triangle intersection unit.
`default_nettype none

module ray_triangle_intersect_tb;
  import rti_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [EPS_W-1:0] cfg_wdata = '0;
  logic             req_valid = 1'b0;
  logic             req_ready;
  rti_req_t         req = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  rti_rsp_t         rsp;

  ray_triangle_intersect DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always #5 clk = ~clk;

  localparam logic signed [31:0] ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] HALF = 32'sh0000_8000;
  localparam logic signed [31:0] QTR  = 32'sh0000_4000;

  // Items waiting to be driven and results the predictor expects.
  rti_req_t pending_q[$];
  rti_rsp_t hit_expect_q[$];

  // Predictor state: triangle corners and the parallel-ray threshold.
  logic signed [31:0] corner_mem [1024][3][3];
  logic [EPS_W-1:0]   eps_now = EPS_RESET;

  // Stimulus view of the triangles, used to aim rays.
  logic signed [31:0] shape_tab [1024][3][3];
  bit [2:0]           corners_set [1024];

  bit no_idle = 1'b0;
  int errors = 0;
  int tests_done = 0;
  int hits_done = 0;
  int stores_done = 0;

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic logic [QUO_W-1:0] floor_ratio(input logic signed [127:0] num,
                                                   input logic signed [127:0] den,
                                                   input int shift,
                                                   input logic [63:0] cap);
    logic [191:0] quo;
    quo = ({64'b0, num} << shift) / {64'b0, den};
    floor_ratio = (quo > {128'b0, cap}) ? cap[QUO_W-1:0] : quo[QUO_W-1:0];
  endfunction

  // Exact Moller-Trumbore prediction for one accepted item.
  function automatic void predict_item(input rti_req_t r);
    logic signed [127:0] org[3], dir[3], e1[3], e2[3], s[3], p[3], q[3];
    logic signed [127:0] det, nu, nv, nt, mag, thr;
    rti_rsp_t res;
    if (r.func == FUNC_STORE) begin
      stores_done++;
      if (r.corner < 2'd3) begin
        corner_mem[r.tri_index][r.corner][0] = r.pos_x;
        corner_mem[r.tri_index][r.corner][1] = r.pos_y;
        corner_mem[r.tri_index][r.corner][2] = r.pos_z;
      end
      return;
    end
    tests_done++;
    res = '0;
    res.tri_echo = r.tri_index;
    org[0] = r.pos_x; org[1] = r.pos_y; org[2] = r.pos_z;
    dir[0] = r.dir_x; dir[1] = r.dir_y; dir[2] = r.dir_z;
    for (int i = 0; i < 3; i++) begin
      e1[i] = corner_mem[r.tri_index][1][i] - corner_mem[r.tri_index][0][i];
      e2[i] = corner_mem[r.tri_index][2][i] - corner_mem[r.tri_index][0][i];
      s[i]  = org[i] - corner_mem[r.tri_index][0][i];
    end
    p[0] = dir[1] * e2[2] - dir[2] * e2[1];
    p[1] = dir[2] * e2[0] - dir[0] * e2[2];
    p[2] = dir[0] * e2[1] - dir[1] * e2[0];
    q[0] = s[1] * e1[2] - s[2] * e1[1];
    q[1] = s[2] * e1[0] - s[0] * e1[2];
    q[2] = s[0] * e1[1] - s[1] * e1[0];
    det = 0; nu = 0; nv = 0; nt = 0;
    for (int i = 0; i < 3; i++) begin
      det += p[i] * e1[i];
      nu  += p[i] * s[i];
      nv  += q[i] * dir[i];
      nt  += q[i] * e2[i];
    end
    mag = (det < 0) ? -det : det;
    thr = 128'(eps_now) << 32;
    if (det < 0) begin
      nu = -nu; nv = -nv; nt = -nt;
    end
    // A zero or small determinant means the ray runs parallel to the plane.
    if (det != 0 && mag >= thr && nu >= 0 && nu <= mag && nv >= 0 &&
        nu + nv <= mag && nt >= 0) begin
      res.hit = 1'b1;
      res.bary_u = floor_ratio(nu, mag, BARY_FRAC, 64'd1 << 30);
      res.bary_v = floor_ratio(nv, mag, BARY_FRAC, 64'd1 << 30);
      res.hit_distance = floor_ratio(nt, mag, 16, 64'h7FFF_FFFF);
    end
    hit_expect_q = {hit_expect_q, res};
  endfunction

  // Sender: takes the next item from the queue, idling at random.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ready) begin
      if (req_valid) predict_item(req);
      if (pending_q.size() != 0 && (no_idle || $urandom_range(99) >= 37)) begin
        req <= pending_q.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure and comparison with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= no_idle || ($urandom_range(99) >= 37);
      if (rsp_valid && rsp_ready) begin
        if (hit_expect_q.size() == 0) begin
          report("unexpected result", rsp.tri_echo, -1);
        end else begin
          rti_rsp_t want;
          want = hit_expect_q.pop_front();
          if (want.hit) hits_done++;
          if (rsp.hit != want.hit) report("hit", rsp.hit, want.hit);
          if (rsp.tri_echo != want.tri_echo) report("tri_echo", rsp.tri_echo, want.tri_echo);
          if (rsp.bary_u != want.bary_u) report("bary_u", rsp.bary_u, want.bary_u);
          if (rsp.bary_v != want.bary_v) report("bary_v", rsp.bary_v, want.bary_v);
          if (rsp.hit_distance != want.hit_distance)
            report("hit_distance", rsp.hit_distance, want.hit_distance);
        end
      end
    end
  end

  task automatic store_corner(input int slot, input int c, input logic signed [31:0] x,
                              input logic signed [31:0] y, input logic signed [31:0] z);
    rti_req_t r;
    r = '0;
    r.func = FUNC_STORE;
    r.tri_index = IDX_W'(slot);
    r.corner = CORNER_W'(c);
    r.pos_x = x; r.pos_y = y; r.pos_z = z;
    r.dir_x = $urandom; r.dir_y = $urandom; r.dir_z = $urandom;
    if (c < 3) begin
      shape_tab[slot][c][0] = x; shape_tab[slot][c][1] = y; shape_tab[slot][c][2] = z;
      corners_set[slot][c] = 1'b1;
    end
    pending_q = {pending_q, r};
  endtask

  task automatic send_test(input int slot, input logic signed [31:0] ox,
                           input logic signed [31:0] oy, input logic signed [31:0] oz,
                           input logic signed [31:0] dx, input logic signed [31:0] dy,
                           input logic signed [31:0] dz);
    rti_req_t r;
    r.func = FUNC_TEST;
    r.tri_index = IDX_W'(slot);
    r.corner = CORNER_W'($urandom_range(3));
    r.pos_x = ox; r.pos_y = oy; r.pos_z = oz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    pending_q = {pending_q, r};
  endtask

  // Ray from a random origin to or from the point at weights ai/16, bi/16 of edges.
  task automatic aimed_test(input int slot, input int ai, input int bi, input int mode);
    longint tgt[3], org[3], dv[3];
    for (int i = 0; i < 3; i++) begin
      tgt[i] = longint'(shape_tab[slot][0][i]) +
               ((longint'(shape_tab[slot][1][i]) - shape_tab[slot][0][i]) * ai +
                (longint'(shape_tab[slot][2][i]) - shape_tab[slot][0][i]) * bi) / 16;
      org[i] = longint'(tgt[i]) + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      dv[i] = tgt[i] - org[i];
      if (mode == 1) dv[i] = -dv[i];
      if (mode == 2) dv[i] = dv[i] / 2;
    end
    send_test(slot, 32'(org[0]), 32'(org[1]), 32'(org[2]),
              32'(dv[0]), 32'(dv[1]), 32'(dv[2]));
  endtask

  function automatic logic signed [31:0] rand_coord();
    if ($urandom_range(9) < 7) return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    return $urandom;
  endfunction

  task automatic random_triangle(input int slot);
    int order;
    order = $urandom_range(1);
    for (int k = 0; k < 3; k++)
      store_corner(slot, order ? 2 - k : k, rand_coord(), rand_coord(), rand_coord());
  endtask

  // Holds until everything sent has been answered, then lets the pipeline drain.
  task automatic drain();
    while (pending_q.size() != 0 || req_valid || hit_expect_q.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_eps(input logic [EPS_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    eps_now = value;
  endtask

  // A small pool of slots keeps tests landing on filled triangles.
  task automatic random_phase(input int count);
    int slot, sel;
    for (int n = 0; n < count; n++) begin
      slot = $urandom_range(47);
      sel = $urandom_range(99);
      if (corners_set[slot] != 3'b111 || sel < 15) begin
        random_triangle(slot);
      end else if (sel < 20) begin
        store_corner(slot, 3, $urandom, $urandom, $urandom);
      end else if (sel < 65) begin
        aimed_test(slot, $urandom_range(16), 0, 0);
        aimed_test(slot, 0, 0, $urandom_range(2)) ;
      end else if (sel < 80) begin
        aimed_test(slot, $urandom_range(20), $urandom_range(20), $urandom_range(2));
      end else begin
        send_test(slot, rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord());
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset threshold: unit triangle in slot 0, slots 5 and 1023.
    store_corner(0, 0, 0, 0, 0);
    store_corner(0, 1, ONE, 0, 0);
    store_corner(0, 2, 0, ONE, 0);
    store_corner(0, 3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
    store_corner(5, 0, 0, 0, 0);
    store_corner(5, 1, 0, 0, 0);
    store_corner(5, 2, 0, 0, 0);
    store_corner(1023, 0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    store_corner(1023, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    store_corner(1023, 2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_test(0, QTR, QTR, -ONE, 0, 0, ONE);
    send_test(0, 0, 0, -ONE, 0, 0, ONE);
    send_test(0, ONE, 0, -ONE, 0, 0, ONE);
    send_test(0, 0, ONE, -ONE, 0, 0, ONE);
    send_test(0, HALF, HALF, -ONE, 0, 0, ONE);
    send_test(0, QTR, QTR, 0, 0, 0, ONE);
    send_test(0, QTR, QTR, ONE, 0, 0, ONE);
    send_test(0, -QTR, QTR, -ONE, 0, 0, ONE);
    send_test(0, QTR, QTR, -ONE, ONE, 0, 0);
    send_test(0, QTR, QTR, 32'h8000_0000, 0, 0, 1);
    send_test(5, QTR, QTR, -ONE, 0, 0, ONE);
    send_test(1023, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_test(1023, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);

    // Zero threshold: only an exactly zero determinant is parallel.
    write_eps('0);
    send_test(5, QTR, QTR, -ONE, 0, 0, ONE);
    send_test(0, QTR, QTR, -ONE, ONE, 0, 0);
    send_test(0, QTR, QTR, -ONE, 0, 0, 1);

    // Largest threshold rejects small triangles.
    write_eps('1);
    send_test(0, QTR, QTR, -ONE, 0, 0, ONE);
    random_phase(24);

    // Random phases under various thresholds, the third with no idling.
    write_eps(EPS_RESET);
    random_phase(40);
    write_eps(EPS_W'($urandom_range(1, 65534)));
    random_phase(40);
    write_eps(EPS_W'($urandom_range(0, 3)));
    no_idle = 1'b1;
    random_phase(40);
    drain();
    no_idle = 1'b0;
    random_phase(30);

    drain();
    $display("Covered %0d store items and %0d ray tests, %0d of which hit.",
             stores_done, tests_done, hits_done);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
